// ===== hw/rtl/cc_pkg.sv =====
// Shared types and constants for the circle contact pipeline.
// No dependencies; cc_div_pipe and circle_circle_contact import it.
package cc_pkg;

    localparam int unsigned DIST_W = 31;    // distance and radius sum, unsigned Q15.16
    localparam int unsigned FRIC_W = 16;    // root of a Q1.15 product
    localparam int unsigned QUO_W  = 16;    // normal quotient bits

    localparam logic [15:0] EPS_RESET   = 16'd1;
    localparam logic [15:0] Q15_ONE     = 16'd32768;
    localparam logic [15:0] Q15_MAX     = 16'h7FFF;
    localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;

    // Geometry that travels alongside the arithmetic units.
    typedef struct packed {
        logic              hit;
        logic              sx;
        logic              sy;
        logic [DIST_W-1:0] udx;
        logic [DIST_W-1:0] udy;
        logic [DIST_W-1:0] rsum;
        logic [29:0]       arad;
        logic [31:0]       ax;
        logic [31:0]       ay;
    } geo_t;

endpackage

// ===== hw/rtl/cc_delay.sv =====
// Fixed-length register delay line used to keep side data aligned.
// Depends on nothing.
module cc_delay #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/cc_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing; the caller keeps valid bits and side data aligned.
module cc_sqrt_pipe #(
    parameter int unsigned OUT_W = 16
) (
    input  logic                 clk,
    input  logic [2*OUT_W-1:0]   radicand,
    output logic [OUT_W-1:0]     root
);

    localparam int unsigned IN_W  = 2 * OUT_W;
    localparam int unsigned REM_W = OUT_W + 3;

    logic [REM_W-1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  rad_reg  [OUT_W];

    for (genvar g = 0; g < OUT_W; g++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  rad_in;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic             fits;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        // Bring down the next two radicand bits and try a one in this place.
        assign shifted = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};
        assign fits    = (shifted >= trial);

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= fits ? (shifted - trial) : shifted;
            root_reg[g] <= {root_in[OUT_W-2:0], fits};
            rad_reg[g]  <= {rad_in[IN_W-3:0], 2'b00};
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

// ===== hw/rtl/cc_div_pipe.sv =====
// Pipelined restoring divider for both normal components, sharing one divisor.
// Computes (mag << 15) / dist for mag <= dist; imports cc_pkg.
module cc_div_pipe (
    input  logic                       clk,
    input  logic [cc_pkg::DIST_W-1:0]  mag_x,
    input  logic [cc_pkg::DIST_W-1:0]  mag_y,
    input  logic [cc_pkg::DIST_W-1:0]  divisor,
    output logic [cc_pkg::QUO_W-1:0]   quo_x,
    output logic [cc_pkg::QUO_W-1:0]   quo_y,
    output logic [cc_pkg::DIST_W-1:0]  divisor_out
);
    import cc_pkg::*;

    logic [DIST_W-1:0] remx_reg [QUO_W];
    logic [DIST_W-1:0] remy_reg [QUO_W];
    logic [QUO_W-1:0]  qx_reg   [QUO_W];
    logic [QUO_W-1:0]  qy_reg   [QUO_W];
    logic [DIST_W-1:0] div_reg  [QUO_W];

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_stage
        logic [DIST_W:0]   shx;
        logic [DIST_W:0]   shy;
        logic [DIST_W:0]   dv;
        logic [DIST_W-1:0] dv_in;
        logic [QUO_W-1:0]  qx_in;
        logic [QUO_W-1:0]  qy_in;
        logic              gex;
        logic              gey;

        // The first stage starts from mag >> 1 and brings in the low bit of
        // mag; the fifteen zeros below it follow in the later stages.
        if (g == 0)
        begin : g_first
            assign shx   = {1'b0, mag_x};
            assign shy   = {1'b0, mag_y};
            assign dv_in = divisor;
            assign qx_in = '0;
            assign qy_in = '0;
        end
        else
        begin : g_next
            assign shx   = {remx_reg[g-1], 1'b0};
            assign shy   = {remy_reg[g-1], 1'b0};
            assign dv_in = div_reg[g-1];
            assign qx_in = qx_reg[g-1];
            assign qy_in = qy_reg[g-1];
        end

        assign dv  = {1'b0, dv_in};
        assign gex = (shx >= dv);
        assign gey = (shy >= dv);

        always_ff @(posedge clk)
        begin
            remx_reg[g] <= gex ? DIST_W'(shx - dv) : DIST_W'(shx);
            remy_reg[g] <= gey ? DIST_W'(shy - dv) : DIST_W'(shy);
            qx_reg[g]   <= {qx_in[QUO_W-2:0], gex};
            qy_reg[g]   <= {qy_in[QUO_W-2:0], gey};
            div_reg[g]  <= dv_in;
        end
    end

    assign quo_x       = qx_reg[QUO_W-1];
    assign quo_y       = qy_reg[QUO_W-1];
    assign divisor_out = div_reg[QUO_W-1];

endmodule

// ===== hw/rtl/circle_circle_contact.sv =====
// Circle against circle contact test, fully pipelined: one pair may be started
// in every cycle (busy is never raised) and its result word appears with done.
// The pipeline is the distance square root (31 stages, one bit each) followed
// by the normal divider (16 stages), plus three stages in front and three behind.
// There is no back pressure: done lasts one cycle and the word must be taken then.
// normal_epsilon is written through cfg_we and cfg_wdata while no pair is in
// flight; the user must keep to this, as the block does not enforce it.
// Depends on cc_pkg, cc_delay, cc_sqrt_pipe and cc_div_pipe.
module circle_circle_contact (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic [31:0] a_pos_x,
    input  logic [31:0] a_pos_y,
    input  logic [29:0] a_rad,
    input  logic [31:0] b_pos_x,
    input  logic [31:0] b_pos_y,
    input  logic [29:0] b_rad,
    input  logic [15:0] a_restit,
    input  logic [15:0] b_restit,
    input  logic [15:0] a_static_fric,
    input  logic [15:0] b_static_fric,
    input  logic [15:0] a_dyn_fric,
    input  logic [15:0] b_dyn_fric,
    output logic        done,
    output logic        hit,
    output logic [15:0] normal_x,
    output logic [15:0] normal_y,
    output logic [30:0] penetration,
    output logic [31:0] contact_x,
    output logic [31:0] contact_y,
    output logic [15:0] restitution_out,
    output logic [15:0] static_fric_out,
    output logic [15:0] dyn_fric_out
);
    import cc_pkg::*;

    localparam int unsigned LAT      = 3 + DIST_W + QUO_W + 3;
    localparam int unsigned FRIC_DLY = LAT - 3 - FRIC_W;
    localparam int unsigned RES_DLY  = LAT - 3;

    logic [15:0]    eps_reg;
    logic [LAT-1:0] vld_reg;

    // ---- front stages ----
    logic [32:0] dx_w, dy_w, adx_w, ady_w;
    geo_t        s1_geo_reg, s2_geo_reg, s3_geo_reg;
    geo_t        s1_geo_next, s3_geo_next;
    logic [15:0] s1_restit_reg, s1_restit_next;
    logic [15:0] s1_asf_reg, s1_bsf_reg, s1_adf_reg, s1_bdf_reg;
    logic [61:0] s2_sqx_reg, s2_sqy_reg, s2_r2_reg;
    logic [31:0] s2_sf_reg, s2_df_reg;
    logic [15:0] s2_restit_reg;
    logic [62:0] dist2_w;
    logic [61:0] s3_rad_reg;

    // ---- back stages ----
    logic [DIST_W-1:0] root_w, dist_w;
    geo_t              geo_sq_w, geo_dv_w;
    logic [QUO_W-1:0]  qx_w, qy_w;
    logic [FRIC_W-1:0] sf_root_w, df_root_w;
    logic [15:0]       sf_cap_w, df_cap_w, sf_d_w, df_d_w, restit_d_w;

    logic signed [15:0] n1_nx_reg, n1_ny_reg, n1_nx_next, n1_ny_next;
    logic [30:0]        n1_pen_reg, n1_pen_next;
    logic signed [32:0] n1_s2_reg, n1_s2_next;
    logic               n1_hit_reg, n2_hit_reg;
    logic [31:0]        n1_ax_reg, n1_ay_reg, n2_ax_reg, n2_ay_reg;
    logic signed [15:0] n2_nx_reg, n2_ny_reg;
    logic [30:0]        n2_pen_reg;
    logic signed [48:0] n2_px_reg, n2_py_reg;
    logic signed [48:0] tx_w, ty_w;
    logic [33:0]        sumx_w, sumy_w;
    logic [31:0]        cx_w, cy_w;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    // Stage 1: differences, magnitudes, the far-apart test and the larger restitution.
    always_comb
    begin
        dx_w  = {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
        dy_w  = {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
        adx_w = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
        ady_w = dy_w[32] ? (~dy_w + 33'd1) : dy_w;
        s1_geo_next.hit  = !(adx_w[32] | adx_w[31] | ady_w[32] | ady_w[31]);
        s1_geo_next.sx   = dx_w[32];
        s1_geo_next.sy   = dy_w[32];
        s1_geo_next.udx  = adx_w[30:0];
        s1_geo_next.udy  = ady_w[30:0];
        s1_geo_next.rsum = {1'b0, a_rad} + {1'b0, b_rad};
        s1_geo_next.arad = a_rad;
        s1_geo_next.ax   = a_pos_x;
        s1_geo_next.ay   = a_pos_y;
        s1_restit_next   = (a_restit > b_restit) ? a_restit : b_restit;
        if (s1_restit_next > Q15_ONE)
        begin
            s1_restit_next = Q15_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_geo_reg    <= s1_geo_next;
        s1_restit_reg <= s1_restit_next;
        s1_asf_reg    <= a_static_fric;
        s1_bsf_reg    <= b_static_fric;
        s1_adf_reg    <= a_dyn_fric;
        s1_bdf_reg    <= b_dyn_fric;
    end

    // Stage 2: squares and friction products.
    always_ff @(posedge clk)
    begin
        s2_geo_reg    <= s1_geo_reg;
        s2_restit_reg <= s1_restit_reg;
        s2_sqx_reg    <= 62'(s1_geo_reg.udx) * 62'(s1_geo_reg.udx);
        s2_sqy_reg    <= 62'(s1_geo_reg.udy) * 62'(s1_geo_reg.udy);
        s2_r2_reg     <= 62'(s1_geo_reg.rsum) * 62'(s1_geo_reg.rsum);
        s2_sf_reg     <= 32'(s1_asf_reg) * 32'(s1_bsf_reg);
        s2_df_reg     <= 32'(s1_adf_reg) * 32'(s1_bdf_reg);
    end

    // Stage 3: squared distance and the contact decision.
    always_comb
    begin
        dist2_w         = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
        s3_geo_next     = s2_geo_reg;
        s3_geo_next.hit = s2_geo_reg.hit && (dist2_w <= {1'b0, s2_r2_reg});
    end

    always_ff @(posedge clk)
    begin
        s3_geo_reg <= s3_geo_next;
        s3_rad_reg <= dist2_w[61:0];
    end

    // Distance root, with the geometry riding alongside.
    cc_sqrt_pipe #(.OUT_W(DIST_W)) u_dist_sqrt (
        .clk      (clk),
        .radicand (s3_rad_reg),
        .root     (root_w)
    );

    cc_delay #(.WIDTH($bits(geo_t)), .DEPTH(DIST_W)) u_geo_sq (
        .clk (clk),
        .d   (s3_geo_reg),
        .q   (geo_sq_w)
    );

    cc_div_pipe u_div (
        .clk         (clk),
        .mag_x       (geo_sq_w.udx),
        .mag_y       (geo_sq_w.udy),
        .divisor     (root_w),
        .quo_x       (qx_w),
        .quo_y       (qy_w),
        .divisor_out (dist_w)
    );

    cc_delay #(.WIDTH($bits(geo_t)), .DEPTH(QUO_W)) u_geo_dv (
        .clk (clk),
        .d   (geo_sq_w),
        .q   (geo_dv_w)
    );

    // Friction means run beside the geometry and wait for it.
    cc_sqrt_pipe #(.OUT_W(FRIC_W)) u_sf_sqrt (
        .clk      (clk),
        .radicand (s2_sf_reg),
        .root     (sf_root_w)
    );

    cc_sqrt_pipe #(.OUT_W(FRIC_W)) u_df_sqrt (
        .clk      (clk),
        .radicand (s2_df_reg),
        .root     (df_root_w)
    );

    assign sf_cap_w = (sf_root_w > Q15_ONE) ? Q15_ONE : sf_root_w;
    assign df_cap_w = (df_root_w > Q15_ONE) ? Q15_ONE : df_root_w;

    cc_delay #(.WIDTH(32), .DEPTH(FRIC_DLY)) u_fric_dly (
        .clk (clk),
        .d   ({sf_cap_w, df_cap_w}),
        .q   ({sf_d_w, df_d_w})
    );

    cc_delay #(.WIDTH(16), .DEPTH(RES_DLY)) u_res_dly (
        .clk (clk),
        .d   (s2_restit_reg),
        .q   (restit_d_w)
    );

    // Back stage 1: normal with fallback, penetration and contact lever.
    always_comb
    begin
        if (dist_w > {15'd0, eps_reg})
        begin
            if (geo_dv_w.sx)
            begin
                n1_nx_next = -$signed(qx_w);
            end
            else
            begin
                n1_nx_next = qx_w[15] ? $signed(Q15_MAX) : $signed(qx_w);
            end
            if (geo_dv_w.sy)
            begin
                n1_ny_next = -$signed(qy_w);
            end
            else
            begin
                n1_ny_next = qy_w[15] ? $signed(Q15_MAX) : $signed(qy_w);
            end
        end
        else
        begin
            n1_nx_next = '0;
            n1_ny_next = $signed(Q15_MAX);
        end
        n1_pen_next = geo_dv_w.rsum - dist_w;
        n1_s2_next  = $signed({2'b00, geo_dv_w.arad, 1'b0}) - $signed({2'b00, n1_pen_next});
    end

    always_ff @(posedge clk)
    begin
        n1_nx_reg  <= n1_nx_next;
        n1_ny_reg  <= n1_ny_next;
        n1_pen_reg <= n1_pen_next;
        n1_s2_reg  <= n1_s2_next;
        n1_hit_reg <= geo_dv_w.hit;
        n1_ax_reg  <= geo_dv_w.ax;
        n1_ay_reg  <= geo_dv_w.ay;
    end

    // Back stage 2: offset products.
    always_ff @(posedge clk)
    begin
        n2_px_reg  <= 49'(n1_nx_reg) * 49'(n1_s2_reg);
        n2_py_reg  <= 49'(n1_ny_reg) * 49'(n1_s2_reg);
        n2_nx_reg  <= n1_nx_reg;
        n2_ny_reg  <= n1_ny_reg;
        n2_pen_reg <= n1_pen_reg;
        n2_hit_reg <= n1_hit_reg;
        n2_ax_reg  <= n1_ax_reg;
        n2_ay_reg  <= n1_ay_reg;
    end

    // Back stage 3: round to nearest, add the centre of A and saturate.
    always_comb
    begin
        tx_w   = (n2_px_reg + 49'sd32768) >>> 16;
        ty_w   = (n2_py_reg + 49'sd32768) >>> 16;
        sumx_w = {tx_w[32], tx_w[32:0]} + {{2{n2_ax_reg[31]}}, n2_ax_reg};
        sumy_w = {ty_w[32], ty_w[32:0]} + {{2{n2_ay_reg[31]}}, n2_ay_reg};
        if (sumx_w[33] == sumx_w[32] && sumx_w[32] == sumx_w[31])
        begin
            cx_w = sumx_w[31:0];
        end
        else
        begin
            cx_w = sumx_w[33] ? S32_MIN : S32_MAX;
        end
        if (sumy_w[33] == sumy_w[32] && sumy_w[32] == sumy_w[31])
        begin
            cy_w = sumy_w[31:0];
        end
        else
        begin
            cy_w = sumy_w[33] ? S32_MIN : S32_MAX;
        end
    end

    // A word without contact carries zeros in every field.
    always_ff @(posedge clk)
    begin
        hit             <= n2_hit_reg;
        normal_x        <= n2_hit_reg ? n2_nx_reg : '0;
        normal_y        <= n2_hit_reg ? n2_ny_reg : '0;
        penetration     <= n2_hit_reg ? n2_pen_reg : '0;
        contact_x       <= n2_hit_reg ? cx_w : '0;
        contact_y       <= n2_hit_reg ? cy_w : '0;
        restitution_out <= n2_hit_reg ? restit_d_w : '0;
        static_fric_out <= n2_hit_reg ? sf_d_w : '0;
        dyn_fric_out    <= n2_hit_reg ? df_d_w : '0;
    end

    assign done = vld_reg[LAT-1];

endmodule
